@@ src/hsl_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, types and constants of the HSL color adjust pipeline.
// No dependencies; every other file refers to it by scoped names.
package hsl_pkg;

    localparam int CB       = 16;
    localparam int OFF_W    = CB + 1;
    localparam int CFG_W    = (OFF_W > 16) ? OFF_W : 16;
    localparam int QW       = 17;
    localparam int HUE_W    = 16;
    localparam int ACH_LIM  = ((2 ** CB) - 1) / 10000;
    localparam int SAT_LIM  = 65535 / 10000;
    localparam int ONE_Q16  = 65536;
    localparam int GAIN_RST = 16384;

    typedef logic [CB-1:0]         t_chan;
    typedef logic [CB:0]           t_sum;
    typedef logic [CB+2:0]         t_n;
    typedef logic [CB+20:0]        t_dvd;
    typedef logic [CB+3:0]         t_dvs;
    typedef logic [QW-1:0]         t_quo;
    typedef logic [HUE_W-1:0]      t_hue;
    typedef logic [32:0]           t_sg;
    typedef logic [18:0]           t_sgr;
    typedef logic signed [CB+2:0]  t_lt;
    typedef logic [CB+17:0]        t_pq;
    typedef logic [CB+19:0]        t_pqx;
    typedef logic [CB+2:0]         t_rnd;
    typedef logic [18:0]           t_u;
    typedef logic [19:0]           t_ux;
    typedef logic [16:0]           t_w;
    typedef logic [CB+34:0]        t_prod;
    typedef logic [CB+33:0]        t_ls;
    typedef logic [OFF_W-1:0]      t_loff;
    typedef logic [CFG_W-1:0]      t_cfg;

    typedef enum logic [1:0] {
        REG_HUE  = 2'd0,
        REG_GAIN = 2'd1,
        REG_LOFF = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic  chrom;
        logic  s_ok;
        t_sum  sum;
        t_chan alpha;
        logic  last;
    } t_side;

    typedef struct packed {
        t_side side;
        t_dvd  s_dvd;
        t_dvs  s_dvs;
        t_dvd  h_dvd;
        t_dvs  h_dvs;
    } t_front;

    typedef struct packed {
        t_side side;
        t_quo  s_q;
        t_quo  h_q;
    } t_mid;

endpackage

@@ src/hsl_front.sv @@
`timescale 1ns / 1ps
// RGB to HSL front stage: max/min, chroma, lightness sum and divider operands.
// Depends on hsl_pkg.
module hsl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  hsl_pkg::t_chan  i_red,
    input  hsl_pkg::t_chan  i_green,
    input  hsl_pkg::t_chan  i_blue,
    input  hsl_pkg::t_chan  i_alpha,
    input  logic            i_last,
    output logic            o_vld,
    output hsl_pkg::t_front o_f
);

    hsl_pkg::t_chan  mx, mn, delta;
    hsl_pkg::t_sum   sum, den, cmax2;
    hsl_pkg::t_n     d3, d6, n;
    hsl_pkg::t_dvs   dd;
    logic            chrom;
    hsl_pkg::t_front n_f;
    logic            r_vld;
    hsl_pkg::t_front r_f;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        delta = mx - mn;
        sum   = hsl_pkg::t_sum'(mx) + hsl_pkg::t_sum'(mn);
        cmax2 = {{hsl_pkg::CB{1'b1}}, 1'b0};
        den   = (sum > hsl_pkg::t_sum'({hsl_pkg::CB{1'b1}})) ? (cmax2 - sum) : sum;
        chrom = (delta > hsl_pkg::t_chan'(hsl_pkg::ACH_LIM));
        d3 = hsl_pkg::t_n'(delta);
        d6 = (d3 << 2) + (d3 << 1);
        if (mx == i_red) begin
            n = (i_green >= i_blue) ? hsl_pkg::t_n'(i_green - i_blue)
                                    : (d6 - hsl_pkg::t_n'(i_blue - i_green));
        end else if (mx == i_green) begin
            n = (d3 << 1) + hsl_pkg::t_n'(i_blue) - hsl_pkg::t_n'(i_red);
        end else begin
            n = (d3 << 2) + hsl_pkg::t_n'(i_red) - hsl_pkg::t_n'(i_green);
        end
        dd = hsl_pkg::t_dvs'(delta);
        n_f.side.chrom = chrom;
        n_f.side.s_ok  = (den != '0);
        n_f.side.sum   = sum;
        n_f.side.alpha = i_alpha;
        n_f.side.last  = i_last;
        n_f.s_dvd = (hsl_pkg::t_dvd'(delta) << 17) + hsl_pkg::t_dvd'(den);
        n_f.s_dvs = (chrom && (den != '0)) ? (hsl_pkg::t_dvs'(den) << 1)
                                           : hsl_pkg::t_dvs'(1);
        n_f.h_dvd = (hsl_pkg::t_dvd'(n) << 17) + hsl_pkg::t_dvd'(d6);
        n_f.h_dvs = chrom ? ((dd << 3) + (dd << 2)) : hsl_pkg::t_dvs'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f <= n_f;
        end
    end

    assign o_vld = r_vld;
    assign o_f   = r_f;

endmodule

@@ src/hsl_div.sv @@
`timescale 1ns / 1ps
// Twin restoring dividers for saturation and hue, one quotient bit per stage.
// Depends on hsl_pkg.
module hsl_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  hsl_pkg::t_front i_f,
    output logic            o_vld,
    output hsl_pkg::t_mid   o_m
);

    logic           r_vld  [hsl_pkg::QW];
    hsl_pkg::t_dvd  r_srem [hsl_pkg::QW];
    hsl_pkg::t_dvd  r_hrem [hsl_pkg::QW];
    hsl_pkg::t_dvs  r_sdvs [hsl_pkg::QW];
    hsl_pkg::t_dvs  r_hdvs [hsl_pkg::QW];
    hsl_pkg::t_quo  r_sq   [hsl_pkg::QW];
    hsl_pkg::t_quo  r_hq   [hsl_pkg::QW];
    hsl_pkg::t_side r_side [hsl_pkg::QW];

    for (genvar k = 0; k < hsl_pkg::QW; k++) begin : g_st
        logic           vld_i;
        hsl_pkg::t_dvd  srem_i, hrem_i, ssh, hsh;
        hsl_pkg::t_dvs  sdvs_i, hdvs_i;
        hsl_pkg::t_quo  sq_i, hq_i;
        hsl_pkg::t_side side_i;
        logic           sbit, hbit;

        if (k == 0) begin : g_head
            assign vld_i  = i_vld;
            assign srem_i = i_f.s_dvd;
            assign hrem_i = i_f.h_dvd;
            assign sdvs_i = i_f.s_dvs;
            assign hdvs_i = i_f.h_dvs;
            assign sq_i   = '0;
            assign hq_i   = '0;
            assign side_i = i_f.side;
        end else begin : g_body
            assign vld_i  = r_vld[k-1];
            assign srem_i = r_srem[k-1];
            assign hrem_i = r_hrem[k-1];
            assign sdvs_i = r_sdvs[k-1];
            assign hdvs_i = r_hdvs[k-1];
            assign sq_i   = r_sq[k-1];
            assign hq_i   = r_hq[k-1];
            assign side_i = r_side[k-1];
        end

        assign ssh  = hsl_pkg::t_dvd'(sdvs_i) << (hsl_pkg::QW - 1 - k);
        assign hsh  = hsl_pkg::t_dvd'(hdvs_i) << (hsl_pkg::QW - 1 - k);
        assign sbit = (srem_i >= ssh);
        assign hbit = (hrem_i >= hsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[k] <= sbit ? (srem_i - ssh) : srem_i;
                r_hrem[k] <= hbit ? (hrem_i - hsh) : hrem_i;
                r_sdvs[k] <= sdvs_i;
                r_hdvs[k] <= hdvs_i;
                r_sq[k]   <= {sq_i[hsl_pkg::QW-2:0], sbit};
                r_hq[k]   <= {hq_i[hsl_pkg::QW-2:0], hbit};
                r_side[k] <= side_i;
            end
        end
    end

    assign o_vld    = r_vld[hsl_pkg::QW-1];
    assign o_m.side = r_side[hsl_pkg::QW-1];
    assign o_m.s_q  = r_sq[hsl_pkg::QW-1];
    assign o_m.h_q  = r_hq[hsl_pkg::QW-1];

endmodule

@@ src/hsl_back.sv @@
`timescale 1ns / 1ps
// HSL adjust and HSL to RGB back end: five register stages, last is the output.
// Depends on hsl_pkg.
module hsl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  hsl_pkg::t_mid  i_m,
    input  hsl_pkg::t_hue  i_hue_rot,
    input  hsl_pkg::t_hue  i_gain,
    input  hsl_pkg::t_loff i_loff,
    output logic           o_vld,
    output hsl_pkg::t_chan o_red,
    output hsl_pkg::t_chan o_green,
    output hsl_pkg::t_chan o_blue,
    output hsl_pkg::t_chan o_alpha,
    output logic           o_last
);

    typedef enum logic [1:0] {SEC_RISE, SEC_HIGH, SEC_FALL, SEC_LOW} t_sect;

    // stage 1
    hsl_pkg::t_quo  sat0;
    hsl_pkg::t_hue  hue0;
    hsl_pkg::t_lt   lt;
    hsl_pkg::t_sum  l2n;
    logic           r1_vld;
    hsl_pkg::t_hue  r1_hue;
    hsl_pkg::t_sg   r1_sg;
    hsl_pkg::t_sum  r1_l2;
    hsl_pkg::t_chan r1_a;
    logic           r1_last;
    // stage 2
    hsl_pkg::t_sgr  sgr;
    hsl_pkg::t_quo  sat2;
    logic           r2_vld;
    hsl_pkg::t_hue  r2_hue;
    hsl_pkg::t_quo  r2_sat;
    hsl_pkg::t_sum  r2_l2;
    hsl_pkg::t_ls   r2_ls;
    logic           r2_achro;
    hsl_pkg::t_chan r2_a;
    logic           r2_last;
    // stage 3
    hsl_pkg::t_pq   lw, s2c, qn, pn;
    hsl_pkg::t_u    h6;
    hsl_pkg::t_ux   urx, ubx;
    logic           r3_vld;
    hsl_pkg::t_pq   r3_p, r3_q;
    hsl_pkg::t_u    r3_u [3];
    logic           r3_achro;
    hsl_pkg::t_chan r3_avg;
    hsl_pkg::t_chan r3_a;
    logic           r3_last;
    // stage 4
    hsl_pkg::t_w    w    [3];
    t_sect          sect [3];
    logic           r4_vld;
    hsl_pkg::t_prod r4_prod [3];
    t_sect          r4_sect [3];
    hsl_pkg::t_pq   r4_p, r4_q;
    logic           r4_achro;
    hsl_pkg::t_chan r4_avg;
    hsl_pkg::t_chan r4_a;
    logic           r4_last;
    // stage 5
    hsl_pkg::t_pqx  v   [3];
    hsl_pkg::t_rnd  rnd [3];
    hsl_pkg::t_chan ch  [3];
    logic           r5_vld;
    hsl_pkg::t_chan r5_ch [3];
    hsl_pkg::t_chan r5_a;
    logic           r5_last;

    always_comb begin
        if (i_m.side.chrom && i_m.side.s_ok) begin
            sat0 = (i_m.s_q > hsl_pkg::t_quo'(hsl_pkg::ONE_Q16))
                 ? hsl_pkg::t_quo'(hsl_pkg::ONE_Q16) : i_m.s_q;
        end else begin
            sat0 = '0;
        end
        hue0 = i_m.side.chrom ? i_m.h_q[hsl_pkg::HUE_W-1:0] : '0;
        lt = $signed(hsl_pkg::t_lt'(i_m.side.sum))
           + ($signed({{2{i_loff[hsl_pkg::OFF_W-1]}}, i_loff}) <<< 1);
        if (lt[hsl_pkg::CB+2]) begin
            l2n = '0;
        end else if (lt > $signed(hsl_pkg::t_lt'({{hsl_pkg::CB{1'b1}}, 1'b0}))) begin
            l2n = {{hsl_pkg::CB{1'b1}}, 1'b0};
        end else begin
            l2n = lt[hsl_pkg::CB:0];
        end
    end

    always_comb begin
        sgr  = hsl_pkg::t_sgr'((r1_sg + hsl_pkg::t_sg'(8192)) >> 14);
        sat2 = (sgr > hsl_pkg::t_sgr'(hsl_pkg::ONE_Q16))
             ? hsl_pkg::t_quo'(hsl_pkg::ONE_Q16) : sgr[hsl_pkg::QW-1:0];
    end

    always_comb begin
        lw  = hsl_pkg::t_pq'(r2_l2) << 16;
        s2c = (hsl_pkg::t_pq'(r2_sat) << (hsl_pkg::CB + 1)) - (hsl_pkg::t_pq'(r2_sat) << 1);
        if (r2_l2 < hsl_pkg::t_sum'({hsl_pkg::CB{1'b1}})) begin
            qn = lw + hsl_pkg::t_pq'(r2_ls);
        end else begin
            qn = lw + s2c - hsl_pkg::t_pq'(r2_ls);
        end
        pn  = (lw << 1) - qn;
        h6  = (hsl_pkg::t_u'(r2_hue) << 2) + (hsl_pkg::t_u'(r2_hue) << 1);
        urx = hsl_pkg::t_ux'(h6) + hsl_pkg::t_ux'(2 * hsl_pkg::ONE_Q16);
        ubx = hsl_pkg::t_ux'(h6) + hsl_pkg::t_ux'(4 * hsl_pkg::ONE_Q16);
        if (urx >= hsl_pkg::t_ux'(6 * hsl_pkg::ONE_Q16)) begin
            urx = urx - hsl_pkg::t_ux'(6 * hsl_pkg::ONE_Q16);
        end
        if (ubx >= hsl_pkg::t_ux'(6 * hsl_pkg::ONE_Q16)) begin
            ubx = ubx - hsl_pkg::t_ux'(6 * hsl_pkg::ONE_Q16);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r3_u[c] < hsl_pkg::t_u'(hsl_pkg::ONE_Q16)) begin
                sect[c] = SEC_RISE;
                w[c]    = hsl_pkg::t_w'(r3_u[c]);
            end else if (r3_u[c] < hsl_pkg::t_u'(3 * hsl_pkg::ONE_Q16)) begin
                sect[c] = SEC_HIGH;
                w[c]    = '0;
            end else if (r3_u[c] < hsl_pkg::t_u'(4 * hsl_pkg::ONE_Q16)) begin
                sect[c] = SEC_FALL;
                w[c]    = hsl_pkg::t_w'(hsl_pkg::t_u'(4 * hsl_pkg::ONE_Q16) - r3_u[c]);
            end else begin
                sect[c] = SEC_LOW;
                w[c]    = '0;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r4_sect[c])
                SEC_RISE, SEC_FALL: v[c] = hsl_pkg::t_pqx'(r4_p)
                                         + hsl_pkg::t_pqx'(r4_prod[c] >> 16);
                SEC_HIGH:           v[c] = hsl_pkg::t_pqx'(r4_q);
                default:            v[c] = hsl_pkg::t_pqx'(r4_p);
            endcase
            rnd[c] = hsl_pkg::t_rnd'((v[c] + hsl_pkg::t_pqx'(hsl_pkg::ONE_Q16)) >> 17);
            if (r4_achro) begin
                ch[c] = r4_avg;
            end else if (rnd[c] > hsl_pkg::t_rnd'({hsl_pkg::CB{1'b1}})) begin
                ch[c] = {hsl_pkg::CB{1'b1}};
            end else begin
                ch[c] = rnd[c][hsl_pkg::CB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_hue   <= hue0 + i_hue_rot;
            r1_sg    <= hsl_pkg::t_sg'(sat0) * hsl_pkg::t_sg'(i_gain);
            r1_l2    <= l2n;
            r1_a     <= i_m.side.alpha;
            r1_last  <= i_m.side.last;

            r2_hue   <= r1_hue;
            r2_sat   <= sat2;
            r2_l2    <= r1_l2;
            r2_ls    <= hsl_pkg::t_ls'(r1_l2) * hsl_pkg::t_ls'(sat2);
            r2_achro <= (sat2 <= hsl_pkg::t_quo'(hsl_pkg::SAT_LIM));
            r2_a     <= r1_a;
            r2_last  <= r1_last;

            r3_p     <= pn;
            r3_q     <= qn;
            r3_u[0]  <= urx[18:0];
            r3_u[1]  <= h6;
            r3_u[2]  <= ubx[18:0];
            r3_achro <= r2_achro;
            r3_avg   <= hsl_pkg::t_chan'((r2_l2 + hsl_pkg::t_sum'(1)) >> 1);
            r3_a     <= r2_a;
            r3_last  <= r2_last;

            for (int c = 0; c < 3; c++) begin
                r4_prod[c] <= hsl_pkg::t_prod'(r3_q - r3_p) * hsl_pkg::t_prod'(w[c]);
                r4_sect[c] <= sect[c];
                r5_ch[c]   <= ch[c];
            end
            r4_p     <= r3_p;
            r4_q     <= r3_q;
            r4_achro <= r3_achro;
            r4_avg   <= r3_avg;
            r4_a     <= r3_a;
            r4_last  <= r3_last;

            r5_a     <= r4_a;
            r5_last  <= r4_last;
        end
    end

    assign o_vld   = r5_vld;
    assign o_red   = r5_ch[0];
    assign o_green = r5_ch[1];
    assign o_blue  = r5_ch[2];
    assign o_alpha = r5_a;
    assign o_last  = r5_last;

endmodule

@@ src/hsl_color_adjust.sv @@
`timescale 1ns / 1ps
// Top level of the hue / saturation / lightness adjust pipeline.
// Depends on hsl_pkg, hsl_front, hsl_div and hsl_back.
//
//   channel   handshake            payload
//   pixel in  i_valid / o_stall    i_red_in i_green_in i_blue_in i_alpha_in i_last_pixel_in
//   pixel out o_valid / i_stall    o_red_out o_green_out o_blue_out o_alpha_out o_last_pixel_out
//   config    i_cfg_we             i_cfg_idx i_cfg_data
//
// One beat enters per clock unless o_stall is high. The path is one front stage, 17 divider
// stages (one quotient bit each) and five back-end stages ending in the output register.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// A stalled output beat freezes the whole pipeline; o_stall is raised only then.
module hsl_color_adjust (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  hsl_pkg::t_chan  i_red_in,
    input  hsl_pkg::t_chan  i_green_in,
    input  hsl_pkg::t_chan  i_blue_in,
    input  hsl_pkg::t_chan  i_alpha_in,
    input  logic            i_last_pixel_in,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  hsl_pkg::t_cfg   i_cfg_data,
    output logic            o_valid,
    input  logic            i_stall,
    output hsl_pkg::t_chan  o_red_out,
    output hsl_pkg::t_chan  o_green_out,
    output hsl_pkg::t_chan  o_blue_out,
    output hsl_pkg::t_chan  o_alpha_out,
    output logic            o_last_pixel_out
);

    hsl_pkg::t_hue   r_hue_rot;
    hsl_pkg::t_hue   r_gain;
    hsl_pkg::t_loff  r_loff;
    logic            en;
    logic            f_vld, m_vld;
    hsl_pkg::t_front f_data;
    hsl_pkg::t_mid   m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_rot <= '0;
            r_gain    <= hsl_pkg::t_hue'(hsl_pkg::GAIN_RST);
            r_loff    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hsl_pkg::REG_HUE:  r_hue_rot <= i_cfg_data[hsl_pkg::HUE_W-1:0];
                hsl_pkg::REG_GAIN: r_gain    <= i_cfg_data[hsl_pkg::HUE_W-1:0];
                hsl_pkg::REG_LOFF: r_loff    <= i_cfg_data[hsl_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_stall = o_valid & i_stall;
    assign en      = ~o_stall;

    hsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .i_alpha (i_alpha_in),
        .i_last  (i_last_pixel_in),
        .o_vld   (f_vld),
        .o_f     (f_data)
    );

    hsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_f     (f_data),
        .o_vld   (m_vld),
        .o_m     (m_data)
    );

    hsl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (m_vld),
        .i_m       (m_data),
        .i_hue_rot (r_hue_rot),
        .i_gain    (r_gain),
        .i_loff    (r_loff),
        .o_vld     (o_valid),
        .o_red     (o_red_out),
        .o_green   (o_green_out),
        .o_blue    (o_blue_out),
        .o_alpha   (o_alpha_out),
        .o_last    (o_last_pixel_out)
    );

endmodule

@@ src/hsl_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for hsl_color_adjust, attached by bind.
// Depends on hsl_pkg and the top-level port list.
module hsl_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input hsl_pkg::t_chan o_red_out,
    input hsl_pkg::t_chan o_green_out,
    input hsl_pkg::t_chan o_blue_out,
    input hsl_pkg::t_chan o_alpha_out,
    input logic           o_last_pixel_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_red_out) && $stable(o_green_out)
            && $stable(o_blue_out) && $stable(o_alpha_out) && $stable(o_last_pixel_out))
        else $error("stalled output beat changed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall not tied to a waiting output beat");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind hsl_color_adjust hsl_chk u_chk (.*);

@@ tb/tb_hsl_color_adjust.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for hsl_color_adjust: directed and random pixels,
// random idling on both channels, register changes between drained phases.
// Depends on hsl_pkg and the hsl_color_adjust RTL.
module tb_hsl_color_adjust;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam longint unsigned CM   = 65535;
    localparam longint unsigned Q1   = 65536;
    localparam int DRAIN_CYCLES      = 40;
    localparam int HOLD_CYCLES       = 300;
    localparam int WATCHDOG_LIMIT    = 4000;

    typedef struct {
        hsl_pkg::t_chan red;
        hsl_pkg::t_chan green;
        hsl_pkg::t_chan blue;
        hsl_pkg::t_chan alpha;
        logic           last;
    } t_pixel;

    class hsl_scoreboard;
        t_pixel        pending_px[$];
        logic [15:0]   hue_rot;
        logic [15:0]   sat_gain;
        logic [16:0]   light_off;
        int            mismatches;

        function new();
            hue_rot    = 16'd0;
            sat_gain   = 16'd16384;
            light_off  = 17'd0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] idx, hsl_pkg::t_cfg data);
            case (idx)
                hsl_pkg::REG_HUE:  hue_rot   = data[15:0];
                hsl_pkg::REG_GAIN: sat_gain  = data[15:0];
                hsl_pkg::REG_LOFF: light_off = data[16:0];
                default: ;
            endcase
        endfunction

        function longint unsigned interp(longint unsigned u, longint unsigned p,
                                         longint unsigned q);
            longint unsigned v;
            if (u < Q1)
                v = p + (((q - p) * u) >> 16);
            else if (u < 3 * Q1)
                v = q;
            else if (u < 4 * Q1)
                v = p + (((q - p) * (4 * Q1 - u)) >> 16);
            else
                v = p;
            v = (v + Q1) >> 17;
            return (v > CM) ? CM : v;
        endfunction

        function void note_pixel(t_pixel px);
            longint unsigned r, g, b, mx, mn, delta, sum, sat, hue, den, n, l2;
            longint unsigned lw, ls, q, p, h6, v;
            longint lt;
            t_pixel res;
            r = px.red; g = px.green; b = px.blue;
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            delta = mx - mn;
            sum = mx + mn;
            sat = 0;
            hue = 0;
            if (delta * 10000 > CM) begin
                den = (sum > CM) ? (2 * CM - sum) : sum;
                if (den != 0) begin
                    sat = ((delta << 17) + den) / (2 * den);
                    if (sat > Q1) sat = Q1;
                end
                if (mx == r)
                    n = (g >= b) ? (g - b) : (6 * delta - (b - g));
                else if (mx == g)
                    n = 2 * delta + b - r;
                else
                    n = 4 * delta + r - g;
                hue = (((n << 17) + 6 * delta) / (12 * delta)) & 64'hFFFF;
            end
            hue = (hue + hue_rot) & 64'hFFFF;
            sat = (sat * sat_gain + 8192) >> 14;
            if (sat > Q1) sat = Q1;
            lt = longint'(sum) + 2 * longint'($signed(light_off));
            if (lt < 0) lt = 0;
            if (lt > longint'(2 * CM)) lt = longint'(2 * CM);
            l2 = longint'(lt);
            res.alpha = px.alpha;
            res.last  = px.last;
            if (sat * 10000 < Q1) begin
                v = (l2 + 1) >> 1;
                res.red = v[15:0]; res.green = v[15:0]; res.blue = v[15:0];
            end else begin
                lw = l2 << 16;
                ls = l2 * sat;
                h6 = 6 * hue;
                q = (l2 < CM) ? (lw + ls) : (lw + sat * 2 * CM - ls);
                p = 2 * lw - q;
                v = interp((h6 + 2 * Q1) % (6 * Q1), p, q); res.red   = v[15:0];
                v = interp(h6 % (6 * Q1), p, q);            res.green = v[15:0];
                v = interp((h6 + 4 * Q1) % (6 * Q1), p, q); res.blue  = v[15:0];
            end
            pending_px.push_back(res);
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel exp_px;
            if (pending_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h %h %h %h %b",
                             got.red, got.green, got.blue, got.alpha, got.last);
                return;
            end
            exp_px = pending_px.pop_front();
            if (got.red !== exp_px.red || got.green !== exp_px.green ||
                got.blue !== exp_px.blue || got.alpha !== exp_px.alpha ||
                got.last !== exp_px.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                             exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                             exp_px.last, got.red, got.green, got.blue, got.alpha,
                             got.last);
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    hsl_pkg::t_chan i_red_in = '0, i_green_in = '0, i_blue_in = '0, i_alpha_in = '0;
    logic           i_last_pixel_in = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [1:0]     i_cfg_idx = hsl_pkg::REG_HUE;
    hsl_pkg::t_cfg  i_cfg_data = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    hsl_pkg::t_chan o_red_out, o_green_out, o_blue_out, o_alpha_out;
    logic           o_last_pixel_out;

    hsl_scoreboard pixel_sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    hsl_color_adjust dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_pixel(t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red_in <= px.red;
        i_green_in <= px.green;
        i_blue_in <= px.blue;
        i_alpha_in <= px.alpha;
        i_last_pixel_in <= px.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pixel_sb.note_pixel(px);
    endtask

    task automatic write_reg(logic [1:0] idx, hsl_pkg::t_cfg data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pixel_sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_sb.pending_px.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pixel pixel_of(int r, int g, int b, int a, bit l);
        t_pixel px;
        px.red   = hsl_pkg::t_chan'(r);
        px.green = hsl_pkg::t_chan'(g);
        px.blue  = hsl_pkg::t_chan'(b);
        px.alpha = hsl_pkg::t_chan'(a);
        px.last  = l;
        return px;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        int base;
        px = pixel_of($urandom, $urandom, $urandom, $urandom, bit'($urandom_range(1)));
        case ($urandom_range(5))
            0: begin
                base = $urandom_range(65535 - 12);
                px.red   = hsl_pkg::t_chan'(base + $urandom_range(12));
                px.green = hsl_pkg::t_chan'(base + $urandom_range(12));
                px.blue  = hsl_pkg::t_chan'(base + $urandom_range(12));
            end
            1: px.green = px.red;
            2: px.blue = px.green;
            3: begin
                if ($urandom_range(1)) px.red = 16'hFFFF; else px.red = 16'h0;
                if ($urandom_range(1)) px.blue = 16'hFFFF; else px.green = 16'h0;
            end
            default: ;
        endcase
        return px;
    endfunction

    initial begin
        t_pixel got_px;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got_px.red   = o_red_out;
                got_px.green = o_green_out;
                got_px.blue  = o_blue_out;
                got_px.alpha = o_alpha_out;
                got_px.last  = o_last_pixel_out;
                pixel_sb.check_pixel(got_px);
            end
            if (hold_req != 0 && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_hsl_color_adjust: FAIL");
                $finish;
            end
        end
    end

    initial begin
        hsl_pkg::t_cfg hue_set[8]  = '{17'h0, 17'h8000, 17'h7FFF, 17'h0FFF, 17'h0,
                                       17'h1, 17'hFFFF, 17'h4321};
        hsl_pkg::t_cfg gain_set[8] = '{17'd16384, 17'd32768, 17'd0, 17'd65535, 17'd20000,
                                       17'd1, 17'd8000, 17'd16384};
        hsl_pkg::t_cfg loff_set[8] = '{17'h0, 17'h10001, 17'h0FFFF, 17'h10000, 17'h00100,
                                       17'h1FFFF, 17'h1F000, 17'h00000};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(pixel_of(0, 0, 0, 0, 0));
        send_pixel(pixel_of(65535, 65535, 65535, 65535, 1));
        send_pixel(pixel_of(65535, 0, 0, 1, 0));
        send_pixel(pixel_of(0, 65535, 0, 32768, 1));
        send_pixel(pixel_of(0, 0, 65535, 65534, 0));
        send_pixel(pixel_of(65535, 65535, 0, 0, 0));
        send_pixel(pixel_of(0, 65535, 65535, 0, 0));
        send_pixel(pixel_of(65535, 0, 65535, 0, 1));
        send_pixel(pixel_of(30000, 30000, 30000, 0, 0));
        send_pixel(pixel_of(1000, 1006, 1003, 0, 0));
        send_pixel(pixel_of(1000, 1007, 1003, 0, 0));
        send_pixel(pixel_of(65535, 0, 1, 0, 0));
        send_pixel(pixel_of(40000, 10, 11, 0, 0));
        send_pixel(pixel_of(20000, 50000, 35000, 5, 1));
        send_pixel(pixel_of(60000, 60000, 59000, 0, 0));
        send_pixel(pixel_of(100, 200, 300, 65535, 1));
        send_pixel(pixel_of(65535, 65528, 65530, 0, 0));
        drain();

        write_reg(REG_SPARE, 17'h1ABCD);
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(hsl_pkg::REG_HUE,
                      (ph >= 6) ? hsl_pkg::t_cfg'($urandom) : hue_set[ph]);
            write_reg(hsl_pkg::REG_GAIN,
                      (ph == 7) ? hsl_pkg::t_cfg'($urandom_range(32768)) : gain_set[ph]);
            write_reg(hsl_pkg::REG_LOFF,
                      (ph == 7) ? hsl_pkg::t_cfg'($urandom) : loff_set[ph]);
            case (ph % 3)
                0: begin send_idle_pct = 13; recv_idle_pct = 60; end
                1: begin send_idle_pct = 60; recv_idle_pct = 13; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 2) hold_req = 1;
            for (int k = 0; k < 141; k++) send_pixel(rand_pixel());
            drain();
        end

        if (pixel_sb.mismatches == 0)
            $display("tb_hsl_color_adjust: PASS");
        else
            $display("tb_hsl_color_adjust: FAIL");
        $finish;
    end
endmodule
